// File: rtl/gcdiv_pkg.sv
// ---------------------------------------------------------------------------
// gcdiv_pkg
// Shared constants and types for the guarded complex divider.
// ---------------------------------------------------------------------------
package gcdiv_pkg;

  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF  = 16;
  localparam int unsigned THR_WIDTH      = 31;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_DBZ  = 2'd2,
    ST_SAT  = 2'd3
  } status_e;

  // travels alongside each request through the divider cells
  typedef struct packed {
    status_e status;
    logic    neg_re;
    logic    neg_im;
    logic    ovf_re;
    logic    ovf_im;
  } ctrl_t;

endpackage

// File: rtl/gcdiv_front.sv
// ---------------------------------------------------------------------------
// gcdiv_front
// Magnitudes, products, zero guards and divider set-up (six stages).
// ---------------------------------------------------------------------------
module gcdiv_front #(
  parameter int unsigned W  = 32,
  parameter int unsigned F  = 16,
  parameter int unsigned RW = 2 * W + 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [W-1:0]       a_re_i,
  input  logic [W-1:0]       a_im_i,
  input  logic [W-1:0]       b_re_i,
  input  logic [W-1:0]       b_im_i,
  input  logic [W-2:0]       thr_i,
  output logic               valid_o,
  output gcdiv_pkg::ctrl_t   ctrl_o,
  output logic [RW-1:0]      rem_re_o,
  output logic [RW-1:0]      rem_im_o,
  output logic [W-1:0]       low_re_o,
  output logic [W-1:0]       low_im_o,
  output logic [RW-1:0]      den_o
);
  import gcdiv_pkg::*;

  localparam int unsigned PW = 2 * W;
  localparam int unsigned MW = 2 * W + 1;
  localparam int unsigned NW = MW + F + 2;
  localparam int unsigned TW = NW - W;
  localparam int unsigned CW = (TW > RW) ? TW : RW;

  logic [5:0] vld_q;

  // stage 1: sign and magnitude
  logic         na_re_q, na_im_q, nb_re_q, nb_im_q;
  logic [W-1:0] ma_re_q, ma_im_q, mb_re_q, mb_im_q;
  // stage 2: products
  logic [PW-1:0] aa1_q, aa2_q, bb1_q, bb2_q, re1_q, re2_q, im1_q, im2_q, tt_q;
  logic          sre1_q, sre2_q, sim1_q, sim2_q;
  // stage 3: sums
  logic [MW-1:0] mag_a_q, mag_b_q, tt3_q;
  logic [PW-1:0] re1_3q, re2_3q, im1_3q, im2_3q;
  logic          sre1_3q, sre2_3q, sim1_3q, sim2_3q;
  // stage 4: guards and signed sums
  status_e       st4_q;
  logic          nre4_q, nim4_q;
  logic [MW-1:0] num_re4_q, num_im4_q, mag_b4_q;
  // stage 5: scaled dividends
  status_e       st5_q;
  logic          nre5_q, nim5_q;
  logic [NW-1:0] n_re5_q, n_im5_q;
  logic [RW-1:0] den5_q;

  function automatic logic [MW:0] sadd(input logic n1, input logic [PW-1:0] m1,
                                       input logic n2, input logic [PW-1:0] m2);
    logic [MW:0] diff;
    logic [MW:0] res;
    diff = {2'b00, m1} - {2'b00, m2};
    if (n1 == n2) begin
      res = {n1, {1'b0, m1} + {1'b0, m2}};
    end else if (!diff[MW]) begin
      res = {n1, diff[MW-1:0]};
    end else begin
      res = {n2, MW'({1'b0, m2} - {1'b0, m1})};
    end
    return res;
  endfunction

  logic [MW:0]   sum_re, sum_im;
  status_e       st4_d;
  logic [NW-1:0] n_re_d, n_im_d;
  logic [CW-1:0] top_re, top_im, den_ext;

  always_comb begin
    sum_re = sadd(sre1_3q, re1_3q, sre2_3q, re2_3q);
    sum_im = sadd(sim1_3q, im1_3q, sim2_3q, im2_3q);
    if (mag_a_q < tt3_q) begin
      st4_d = ST_ZERO;
    end else if (mag_b_q < tt3_q || mag_b_q == '0) begin
      st4_d = ST_DBZ;
    end else begin
      st4_d = ST_OK;
    end
    // rounded quotient = (num * 2^(F+1) + |b|^2) / (2 |b|^2)
    n_re_d  = (NW'(num_re4_q) << (F + 1)) + NW'(mag_b4_q);
    n_im_d  = (NW'(num_im4_q) << (F + 1)) + NW'(mag_b4_q);
    top_re  = CW'(n_re5_q[NW-1:W]);
    top_im  = CW'(n_im5_q[NW-1:W]);
    den_ext = CW'(den5_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      na_re_q <= a_re_i[W-1];
      na_im_q <= a_im_i[W-1];
      nb_re_q <= b_re_i[W-1];
      nb_im_q <= b_im_i[W-1];
      ma_re_q <= a_re_i[W-1] ? (~a_re_i + 1'b1) : a_re_i;
      ma_im_q <= a_im_i[W-1] ? (~a_im_i + 1'b1) : a_im_i;
      mb_re_q <= b_re_i[W-1] ? (~b_re_i + 1'b1) : b_re_i;
      mb_im_q <= b_im_i[W-1] ? (~b_im_i + 1'b1) : b_im_i;

      aa1_q  <= PW'(ma_re_q) * PW'(ma_re_q);
      aa2_q  <= PW'(ma_im_q) * PW'(ma_im_q);
      bb1_q  <= PW'(mb_re_q) * PW'(mb_re_q);
      bb2_q  <= PW'(mb_im_q) * PW'(mb_im_q);
      re1_q  <= PW'(ma_re_q) * PW'(mb_re_q);
      re2_q  <= PW'(ma_im_q) * PW'(mb_im_q);
      im1_q  <= PW'(ma_im_q) * PW'(mb_re_q);
      im2_q  <= PW'(ma_re_q) * PW'(mb_im_q);
      tt_q   <= PW'(thr_i) * PW'(thr_i);
      sre1_q <= na_re_q ^ nb_re_q;
      sre2_q <= na_im_q ^ nb_im_q;
      sim1_q <= na_im_q ^ nb_re_q;
      sim2_q <= ~(na_re_q ^ nb_im_q);

      mag_a_q <= MW'(aa1_q) + MW'(aa2_q);
      mag_b_q <= MW'(bb1_q) + MW'(bb2_q);
      tt3_q   <= MW'(tt_q);
      re1_3q  <= re1_q;
      re2_3q  <= re2_q;
      im1_3q  <= im1_q;
      im2_3q  <= im2_q;
      sre1_3q <= sre1_q;
      sre2_3q <= sre2_q;
      sim1_3q <= sim1_q;
      sim2_3q <= sim2_q;

      st4_q     <= st4_d;
      nre4_q    <= sum_re[MW];
      nim4_q    <= sum_im[MW];
      num_re4_q <= sum_re[MW-1:0];
      num_im4_q <= sum_im[MW-1:0];
      mag_b4_q  <= mag_b_q;

      st5_q   <= st4_q;
      nre5_q  <= nre4_q;
      nim5_q  <= nim4_q;
      n_re5_q <= n_re_d;
      n_im5_q <= n_im_d;
      den5_q  <= RW'(mag_b4_q) << 1;

      ctrl_o.status <= st5_q;
      ctrl_o.neg_re <= nre5_q;
      ctrl_o.neg_im <= nim5_q;
      // quotient would need more than W bits
      ctrl_o.ovf_re <= top_re >= den_ext;
      ctrl_o.ovf_im <= top_im >= den_ext;
      rem_re_o      <= RW'(n_re5_q[NW-1:W]);
      rem_im_o      <= RW'(n_im5_q[NW-1:W]);
      low_re_o      <= n_re5_q[W-1:0];
      low_im_o      <= n_im5_q[W-1:0];
      den_o         <= den5_q;
    end
  end

  assign valid_o = vld_q[5];

endmodule

// File: rtl/gcdiv_cell.sv
// ---------------------------------------------------------------------------
// gcdiv_cell
// One restoring-division step for both quotient parts.
// ---------------------------------------------------------------------------
module gcdiv_cell #(
  parameter int unsigned W  = 32,
  parameter int unsigned RW = 2 * W + 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  gcdiv_pkg::ctrl_t ctrl_i,
  input  logic [RW-1:0]    rem_re_i,
  input  logic [RW-1:0]    rem_im_i,
  input  logic [W-1:0]     low_re_i,
  input  logic [W-1:0]     low_im_i,
  input  logic [W-1:0]     quo_re_i,
  input  logic [W-1:0]     quo_im_i,
  input  logic [RW-1:0]    den_i,
  output logic             valid_o,
  output gcdiv_pkg::ctrl_t ctrl_o,
  output logic [RW-1:0]    rem_re_o,
  output logic [RW-1:0]    rem_im_o,
  output logic [W-1:0]     low_re_o,
  output logic [W-1:0]     low_im_o,
  output logic [W-1:0]     quo_re_o,
  output logic [W-1:0]     quo_im_o,
  output logic [RW-1:0]    den_o
);
  import gcdiv_pkg::*;

  logic [RW:0] sh_re, sh_im, df_re, df_im;

  always_comb begin
    sh_re = {rem_re_i, low_re_i[W-1]};
    sh_im = {rem_im_i, low_im_i[W-1]};
    df_re = sh_re - {1'b0, den_i};
    df_im = sh_im - {1'b0, den_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctrl_o   <= ctrl_i;
      den_o    <= den_i;
      low_re_o <= low_re_i << 1;
      low_im_o <= low_im_i << 1;
      rem_re_o <= (sh_re >= {1'b0, den_i}) ? df_re[RW-1:0] : sh_re[RW-1:0];
      rem_im_o <= (sh_im >= {1'b0, den_i}) ? df_im[RW-1:0] : sh_im[RW-1:0];
      quo_re_o <= {quo_re_i[W-2:0], sh_re >= {1'b0, den_i}};
      quo_im_o <= {quo_im_i[W-2:0], sh_im >= {1'b0, den_i}};
    end
  end

endmodule

// File: rtl/gcdiv_back.sv
// ---------------------------------------------------------------------------
// gcdiv_back
// Saturation, sign and status of the finished quotient.
// ---------------------------------------------------------------------------
module gcdiv_back #(
  parameter int unsigned W = 32
) (
  input  gcdiv_pkg::ctrl_t ctrl_i,
  input  logic [W-1:0]     quo_re_i,
  input  logic [W-1:0]     quo_im_i,
  output logic [W-1:0]     res_re_o,
  output logic [W-1:0]     res_im_o,
  output logic [1:0]       status_o
);
  import gcdiv_pkg::*;

  logic [W-1:0] lim_re, lim_im, mag_re, mag_im;
  logic         sat_re, sat_im;

  always_comb begin
    lim_re = (W'(1) << (W - 1)) - W'(!ctrl_i.neg_re);
    lim_im = (W'(1) << (W - 1)) - W'(!ctrl_i.neg_im);
    sat_re = ctrl_i.ovf_re || quo_re_i > lim_re;
    sat_im = ctrl_i.ovf_im || quo_im_i > lim_im;
    mag_re = sat_re ? lim_re : quo_re_i;
    mag_im = sat_im ? lim_im : quo_im_i;
    if (ctrl_i.status == ST_OK) begin
      res_re_o = ctrl_i.neg_re ? (~mag_re + 1'b1) : mag_re;
      res_im_o = ctrl_i.neg_im ? (~mag_im + 1'b1) : mag_im;
      status_o = (sat_re || sat_im) ? ST_SAT : ST_OK;
    end else begin
      res_re_o = '0;
      res_im_o = '0;
      status_o = ctrl_i.status;
    end
  end

endmodule

// File: rtl/guarded_complex_divide.sv
// Throughput: one request per cycle unless the output stalls; six set-up
// stages, then a row of DATA_WIDTH division cells, one quotient bit per cell,
// then the output register.
// A stalled output holds the whole pipeline.
// Reset: asynchronous, active low; clears all valid flags, threshold returns to 1.
// ---------------------------------------------------------------------------
// guarded_complex_divide
// Element-wise complex division with a zero guard on dividend and divisor.
// ---------------------------------------------------------------------------
module guarded_complex_divide #(
  parameter int unsigned DATA_WIDTH = gcdiv_pkg::DATA_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = gcdiv_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [gcdiv_pkg::THR_WIDTH-1:0]   cfg_data,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // dividend_re, dividend_im, divisor_re, divisor_im
  input  logic [((4*DATA_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // quotient_re, quotient_im
  output logic [((2*DATA_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  // status
  output logic [1:0]                        m_axis_tuser
);
  import gcdiv_pkg::*;

  localparam int unsigned W  = DATA_WIDTH;
  localparam int unsigned RW = 2 * W + 2;
  localparam int unsigned OW = ((2 * W + 7) / 8) * 8;

  logic         en;
  logic [W-2:0] thr_q;

  logic              vld   [0:W];
  ctrl_t             ctrl  [0:W];
  logic [RW-1:0]     rem_re[0:W];
  logic [RW-1:0]     rem_im[0:W];
  logic [W-1:0]      low_re[0:W];
  logic [W-1:0]      low_im[0:W];
  logic [W-1:0]      quo_re[0:W];
  logic [W-1:0]      quo_im[0:W];
  logic [RW-1:0]     den   [0:W];

  logic [W-1:0] res_re, res_im;
  logic [1:0]   res_st;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= (W - 1)'(1);
    end else if (cfg_valid) begin
      thr_q <= (W - 1)'(cfg_data);
    end
  end

  gcdiv_front #(.W(W), .F(FRAC_BITS), .RW(RW)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (s_axis_tvalid),
    .a_re_i   (s_axis_tdata[W-1:0]),
    .a_im_i   (s_axis_tdata[2*W-1:W]),
    .b_re_i   (s_axis_tdata[3*W-1:2*W]),
    .b_im_i   (s_axis_tdata[4*W-1:3*W]),
    .thr_i    (thr_q),
    .valid_o  (vld[0]),
    .ctrl_o   (ctrl[0]),
    .rem_re_o (rem_re[0]),
    .rem_im_o (rem_im[0]),
    .low_re_o (low_re[0]),
    .low_im_o (low_im[0]),
    .den_o    (den[0])
  );

  assign quo_re[0] = '0;
  assign quo_im[0] = '0;

  for (genvar i = 0; i < W; i++) begin : g_cell
    gcdiv_cell #(.W(W), .RW(RW)) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (en),
      .valid_i  (vld[i]),
      .ctrl_i   (ctrl[i]),
      .rem_re_i (rem_re[i]),
      .rem_im_i (rem_im[i]),
      .low_re_i (low_re[i]),
      .low_im_i (low_im[i]),
      .quo_re_i (quo_re[i]),
      .quo_im_i (quo_im[i]),
      .den_i    (den[i]),
      .valid_o  (vld[i+1]),
      .ctrl_o   (ctrl[i+1]),
      .rem_re_o (rem_re[i+1]),
      .rem_im_o (rem_im[i+1]),
      .low_re_o (low_re[i+1]),
      .low_im_o (low_im[i+1]),
      .quo_re_o (quo_re[i+1]),
      .quo_im_o (quo_im[i+1]),
      .den_o    (den[i+1])
    );
  end

  gcdiv_back #(.W(W)) u_back (
    .ctrl_i   (ctrl[W]),
    .quo_re_i (quo_re[W]),
    .quo_im_i (quo_im[W]),
    .res_re_o (res_re),
    .res_im_o (res_im),
    .status_o (res_st)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= vld[W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_axis_tdata <= OW'({res_im, res_re});
      m_axis_tuser <= res_st;
    end
  end

endmodule

// File: tb/sv/tb_guarded_complex_divide.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_guarded_complex_divide
// Streams complex dividend/divisor pairs through the divider under several
// thresholds and idle patterns; every result is compared with a predicted
// quotient and status, in order.
// ---------------------------------------------------------------------------
module tb_guarded_complex_divide;
  import gcdiv_pkg::*;

  localparam int W = 32;
  localparam int F = 16;
  localparam int LAT = 7 + W;

  typedef struct packed {
    logic [W-1:0] q_re;
    logic [W-1:0] q_im;
    status_e      st;
  } quot_t;

  typedef struct {
    logic [W-1:0] a_re, a_im, b_re, b_im;
    bit           chk;
    quot_t        want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [THR_WIDTH-1:0] cfg_data = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [4*W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [2*W-1:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;

  guarded_complex_divide u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #50ms;
    $display("Verification failed");
    $finish;
  end

  logic [THR_WIDTH-1:0] thr_q = THR_WIDTH'(1);
  quot_t quot_q[$];
  int fails = 0;
  int send_idle = 0, recv_stall = 0;
  bit hold_off = 0;

  // round(|num| * 2^F / den) half away, sign applied, saturated
  function automatic logic [W-1:0] round_sat(input logic signed [67:0] num,
                                             input logic [66:0] den, inout bit sat);
    logic [67:0] mag;
    logic [170:0] q;
    logic signed [W:0] res;
    mag = num[67] ? -num : num;
    q = ((171'(mag) << (F + 1)) + 171'(den)) / (171'(den) << 1);
    if (!num[67] && q > ((171'(1) << (W - 1)) - 171'(1))) begin
      sat = 1; return {1'b0, {(W-1){1'b1}}};
    end
    if (num[67] && q > (171'(1) << (W - 1))) begin
      sat = 1; return {1'b1, {(W-1){1'b0}}};
    end
    res = -$signed({1'b0, q[W-1:0]});
    return num[67] ? res[W-1:0] : q[W-1:0];
  endfunction

  function automatic quot_t divide_guarded(input logic [W-1:0] ar, ai, br, bi,
                                           input logic [THR_WIDTH-1:0] thr);
    quot_t r;
    logic signed [67:0] sar, sai, sbr, sbi;
    logic [66:0] mag_a, mag_b, t2;
    logic signed [67:0] n_re, n_im;
    bit sat;
    sar = $signed(ar); sai = $signed(ai); sbr = $signed(br); sbi = $signed(bi);
    sat = 0;
    r = '{q_re: '0, q_im: '0, st: ST_OK};
    t2 = 67'(thr) * 67'(thr);
    mag_a = 67'(sar * sar) + 67'(sai * sai);
    mag_b = 67'(sbr * sbr) + 67'(sbi * sbi);
    if (mag_a < t2) begin
      r.st = ST_ZERO; return r;
    end
    if (mag_b < t2 || mag_b == 0) begin
      r.st = ST_DBZ; return r;
    end
    n_re = sar * sbr + sai * sbi;
    n_im = sai * sbr - sar * sbi;
    r.q_re = round_sat(n_re, mag_b, sat);
    r.q_im = round_sat(n_im, mag_b, sat);
    r.st = sat ? ST_SAT : ST_OK;
    return r;
  endfunction

  task automatic send_pair(input row_t rw);
    quot_t exp_q;
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {rw.b_im, rw.b_re, rw.a_im, rw.a_re};
    do @(posedge clk_i); while (!s_axis_tready);
    exp_q = divide_guarded(rw.a_re, rw.a_im, rw.b_re, rw.b_im, thr_q);
    if (rw.chk && exp_q != rw.want) begin
      $error("table row disagrees with prediction %h vs %h", rw.want, exp_q);
      fails++;
    end
    quot_q.insert(quot_q.size(), rw.chk ? rw.want : exp_q);
  endtask

  task automatic drain;
    int n;
    n = 0;
    s_axis_tvalid <= 1'b0;
    while (quot_q.size() != 0) @(posedge clk_i);
    while (n < LAT + 4) begin
      @(posedge clk_i); n++;
    end
  endtask

  task automatic set_threshold(input logic [THR_WIDTH-1:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    thr_q = v;
  endtask

  function automatic logic [W-1:0] rand_word();
    case ($urandom_range(5))
      0: return '0;
      1: return {1'b0, {(W-1){1'b1}}};
      2: return {1'b1, {(W-1){1'b0}}};
      3: return W'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      default: return $urandom;
    endcase
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_off) m_axis_tready <= 1'b0;
      else m_axis_tready <= !(recv_stall > 0 && $urandom_range(99) < recv_stall);
      if (m_axis_tvalid && m_axis_tready) begin
        if (quot_q.size() == 0) begin
          $error("result with nothing expected"); fails++;
        end else begin
          quot_t e;
          e = quot_q.pop_front();
          if (m_axis_tdata[W-1:0] !== e.q_re) begin
            $error("quotient_re exp %h got %h", e.q_re, m_axis_tdata[W-1:0]); fails++;
          end
          if (m_axis_tdata[2*W-1:W] !== e.q_im) begin
            $error("quotient_im exp %h got %h", e.q_im, m_axis_tdata[2*W-1:W]); fails++;
          end
          if (m_axis_tuser !== e.st) begin
            $error("status exp %0d got %0d", e.st, m_axis_tuser); fails++;
          end
        end
      end
    end
  end

  localparam logic [W-1:0] MAXP = 32'h7fff_ffff;
  localparam logic [W-1:0] MINN = 32'h8000_0000;
  localparam logic [W-1:0] ONE = 32'h0001_0000;

  initial begin
    row_t tbl[$];
    row_t rw;
    int ph;
    int k;
    tbl = '{
      '{'0, '0, '0, '0, 1, '{'0, '0, ST_ZERO}},
      '{ONE, '0, '0, '0, 1, '{'0, '0, ST_DBZ}},
      '{ONE, '0, ONE, '0, 1, '{ONE, '0, ST_OK}},
      '{'0, ONE, ONE, '0, 1, '{'0, ONE, ST_OK}},
      '{ONE, '0, '0, ONE, 1, '{'0, 32'hffff_0000, ST_OK}},
      '{MAXP, '0, 32'h1, '0, 1, '{MAXP, '0, ST_SAT}},
      '{MINN, '0, 32'h1, '0, 1, '{MINN, '0, ST_SAT}},
      '{MINN, MINN, MINN, MINN, 0, '{'0, '0, ST_OK}},
      '{MAXP, MINN, MINN, MAXP, 0, '{'0, '0, ST_OK}},
      '{32'h1, '0, 32'h3, '0, 0, '{'0, '0, ST_OK}},
      '{32'hffff_ffff, 32'h1, 32'h2, 32'hffff_fffd, 0, '{'0, '0, ST_OK}},
      '{32'h0003_8000, 32'hfffc_0000, 32'h0001_8000, 32'h0002_0000, 0, '{'0, '0, ST_OK}}
    };
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (tbl[i]) send_pair(tbl[i]);

    set_threshold('0);
    send_pair('{'0, '0, '0, '0, 1, '{'0, '0, ST_DBZ}});
    send_pair('{ONE, '0, '0, '0, 1, '{'0, '0, ST_DBZ}});

    for (ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_threshold({THR_WIDTH{1'b1}});
        1: set_threshold(THR_WIDTH'(ONE));
        2: set_threshold(THR_WIDTH'($urandom_range(1, 1 << 18)));
        3: set_threshold(THR_WIDTH'(1));
        default: set_threshold(THR_WIDTH'($urandom));
      endcase
      case (ph)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 62; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 62; end
        3: begin send_idle = 10; recv_stall = 10; end
        default: begin send_idle = 0; recv_stall = 0; end
      endcase
      if (ph == 4) begin
        hold_off = 1;
        fork
          begin
            int c;
            for (c = 0; c < 3 * LAT; c++) @(posedge clk_i);
            hold_off = 0;
          end
        join_none
      end
      for (k = 0; k < 80; k++) begin
        rw.a_re = rand_word(); rw.a_im = rand_word();
        rw.b_re = rand_word(); rw.b_im = rand_word();
        rw.chk = 0; rw.want = '{'0, '0, ST_OK};
        send_pair(rw);
      end
    end
    drain();
    if (fails == 0 && quot_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
